/* sv/plst_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// plst_pkg: shared types and constants of the positional list store
// Command codes, fixed field widths and the control word broadcast to cells.
// ----------------------------------------------------------------------------
package plst_pkg;

	localparam int CMD_W            = 3;
	localparam int POS_W            = 8;
	localparam int VAL_W            = 32;
	localparam int FIDX_W           = 4;
	localparam int ECNT_W           = 5;
	localparam int DEFAULT_CAPACITY = 16;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND = 3'd0,
		CMD_INSERT = 3'd1,
		CMD_REMOVE = 3'd2,
		CMD_GET    = 3'd3,
		CMD_FIND   = 3'd4
	} cmd_e_t;

	// Broadcast to every cell in the transaction's accept cycle.
	typedef struct packed {
		logic             load;  // transaction accepted: refresh compare flags
		logic             ins;   // write value at pos, shift higher cells up
		logic             rem;   // shift cells at and above pos down
		logic [POS_W-1:0] pos;   // position, clamped for insert and remove
		logic [POS_W-1:0] cnt;   // entry count before the operation
		logic [VAL_W-1:0] value;
	} cell_ctrl_t;

endpackage
`default_nettype wire

/* sv/plst_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// plst_cell: one entry of the list chain
// Holds one value, takes a neighbour's value on insert or remove, and flags
// a match against the search value.
// ----------------------------------------------------------------------------
module plst_cell
	import plst_pkg::*;
#(
	parameter int INDEX = 0
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cell_ctrl_t       ctrl,
	input  wire logic [VAL_W-1:0] left_val,
	input  wire logic [VAL_W-1:0] right_val,
	output logic      [VAL_W-1:0] value_q,
	output logic                  match_q
);

	localparam logic [POS_W-1:0] MY_IDX = POS_W'(INDEX);

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (MY_IDX == ctrl.pos) begin
				value_q <= ctrl.value;
			end else if (MY_IDX > ctrl.pos) begin
				value_q <= left_val;
			end
		end else if (ctrl.rem) begin
			if (MY_IDX >= ctrl.pos) begin
				value_q <= right_val;
			end
		end
	end

	// compare against the contents before the operation; find leaves them alone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctrl.load) begin
			match_q <= (value_q == ctrl.value) && (MY_IDX < ctrl.cnt);
		end
	end

endmodule
`default_nettype wire

/* sv/positional_list_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_store: bounded ordered list of 32-bit value tokens
// Append, insert, remove, get and find over a shifting chain of cells.
// ----------------------------------------------------------------------------
// The list lives in a row of CAPACITY cells, entry i in cell i. One command
// arrives per transaction on the slave side, with the command code in tuser
// and position and value in tdata. In the accept cycle every cell shifts,
// writes or compares at once; once the output register is free, the row is
// reduced (get select, first match, last entry) into the result register.
// The slave side takes no new item until the last one has been reduced into
// the result register; a result waiting on the master side holds the reduction
// stage, and the slave side stays closed until that stage is free. The entries
// have no reset: only entries below the count are ever shown.
// ----------------------------------------------------------------------------
module positional_list_store
	import plst_pkg::*;
#(
	parameter int CAPACITY = DEFAULT_CAPACITY
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// slave side
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [39:0]  s_tdata,   // position[7:0], value[39:8]
	input  wire logic [2:0]   s_tuser,   // cmd[2:0]
	// master side
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic      [111:0] m_tdata    // ok[0], read_value[32:1], found[33],
	                                     // found_index[37:34], entry_count[42:38],
	                                     // first_value[74:43], last_value[106:75],
	                                     // zero pad[111:107]
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	// ---------------------------------------------------------------- input
	logic             accept;
	logic [POS_W-1:0] in_pos;
	logic [VAL_W-1:0] in_val;

	assign in_pos = s_tdata[POS_W-1:0];
	assign in_val = s_tdata[POS_W+VAL_W-1:POS_W];
	assign accept = s_tvalid && s_tready;

	// ---------------------------------------------------------------- state
	logic             busy_q;
	logic [CNT_W-1:0] count_q;
	logic             ok_s1;
	logic             is_get_s1;
	logic             is_find_s1;
	logic [POS_W-1:0] pos_s1;

	// ------------------------------------------------------ command decode
	cell_ctrl_t       ctrl;
	logic [POS_W-1:0] cnt_ext;
	logic [POS_W-1:0] last_pos;
	logic             can_add;
	logic             not_empty;
	logic             ok_now;
	logic [CNT_W-1:0] count_next;

	assign cnt_ext   = POS_W'(count_q);
	assign last_pos  = cnt_ext - POS_W'(1);
	assign can_add   = count_q < CAP_CNT;
	assign not_empty = count_q != '0;

	always_comb begin
		ctrl       = '0;
		ctrl.load  = accept;
		ctrl.cnt   = cnt_ext;
		ctrl.value = in_val;
		ok_now     = 1'b0;
		count_next = count_q;
		case (s_tuser)
			CMD_APPEND: begin
				ctrl.pos = cnt_ext;
				if (can_add) begin
					ctrl.ins   = accept;
					ok_now     = 1'b1;
					count_next = count_q + CNT_W'(1);
				end
			end
			CMD_INSERT: begin
				// clamp: a position at or past the end appends
				ctrl.pos = (in_pos >= cnt_ext) ? cnt_ext : in_pos;
				if (can_add) begin
					ctrl.ins   = accept;
					ok_now     = 1'b1;
					count_next = count_q + CNT_W'(1);
				end
			end
			CMD_REMOVE: begin
				// clamp: a position at or past the last entry drops the last
				ctrl.pos = (in_pos >= last_pos) ? last_pos : in_pos;
				if (not_empty) begin
					ctrl.rem   = accept;
					ok_now     = 1'b1;
					count_next = count_q - CNT_W'(1);
				end
			end
			CMD_GET: begin
				ctrl.pos = in_pos;
				ok_now   = in_pos < cnt_ext;
			end
			default: begin
				// find settles ok in the reduction; unused codes change nothing
				ctrl.pos = in_pos;
			end
		endcase
	end

	// ------------------------------------------------------------ the chain
	logic [VAL_W-1:0] cell_val [CAPACITY];
	logic [CAPACITY-1:0] cell_match;

	for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
		logic [VAL_W-1:0] left_v;
		logic [VAL_W-1:0] right_v;

		if (gi == 0) begin : g_head
			assign left_v = ctrl.value;
		end else begin : g_left
			assign left_v = cell_val[gi-1];
		end
		if (gi == CAPACITY - 1) begin : g_tail
			assign right_v = cell_val[gi];
		end else begin : g_right
			assign right_v = cell_val[gi+1];
		end

		plst_cell #(
			.INDEX (gi)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.left_val  (left_v),
			.right_val (right_v),
			.value_q   (cell_val[gi]),
			.match_q   (cell_match[gi])
		);
	end

	// ------------------------------------------------------------ reduction
	logic [CAPACITY-1:0] hit;
	logic [CAPACITY-1:0] first_hit;
	logic [VAL_W-1:0]    rd_acc;
	logic [VAL_W-1:0]    last_acc;
	logic [POS_W-1:0]    fidx_acc;
	logic [POS_W-1:0]    last_idx;
	logic                res_ok;
	logic                res_found;
	logic [VAL_W-1:0]    res_first;
	logic [POS_W-1:0]    cnt_wide;

	assign hit       = is_find_s1 ? cell_match : '0;
	// isolate the lowest set bit: first match in list order
	assign first_hit = hit & (~hit + CAPACITY'(1));
	assign last_idx  = POS_W'(count_q) - POS_W'(1);
	assign cnt_wide  = POS_W'(count_q);

	always_comb begin
		rd_acc   = '0;
		last_acc = '0;
		fidx_acc = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (is_get_s1 && ok_s1 && (pos_s1 == POS_W'(i))) begin
				rd_acc = rd_acc | cell_val[i];
			end
			if (last_idx == POS_W'(i)) begin
				last_acc = last_acc | cell_val[i];
			end
			if (first_hit[i]) begin
				fidx_acc = fidx_acc | POS_W'(i);
			end
		end
	end

	assign res_found = |hit;
	assign res_ok    = is_find_s1 ? res_found : ok_s1;
	assign res_first = (count_q != '0) ? cell_val[0] : '0;

	// ----------------------------------------------------------- handshake
	logic drain;

	// hand the reduced result to the output register once it is free
	assign drain    = busy_q && (!m_tvalid || m_tready);
	assign s_tready = !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			count_q  <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (accept) begin
				busy_q  <= 1'b1;
				count_q <= count_next;
			end else if (drain) begin
				busy_q <= 1'b0;
			end
			if (drain) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	// hold the transaction's decode for the reduction cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			ok_s1      <= ok_now;
			is_get_s1  <= s_tuser == CMD_GET;
			is_find_s1 <= s_tuser == CMD_FIND;
			pos_s1     <= in_pos;
		end
	end

	always_ff @(posedge clk) begin
		if (drain) begin
			m_tdata <= {5'd0,
			            (count_q != '0) ? last_acc : '0,
			            res_first,
			            cnt_wide[ECNT_W-1:0],
			            fidx_acc[FIDX_W-1:0],
			            res_found,
			            rd_acc,
			            res_ok};
		end
	end

	// ----------------------------------------------------------- assertions
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_CNT)
		else $error("entry count above capacity");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("second transaction accepted while one is in flight");

	a_remove_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (s_tuser == CMD_REMOVE) && (count_q != '0)
		|=> count_q == $past(count_q) - CNT_W'(1))
		else $error("remove did not drop one entry");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !m_tvalid |=> m_tvalid)
		else $error("result not loaded while output register free");

endmodule
`default_nettype wire
